[src/smalu_pkg.sv]
// Shared constants, codes and stage structures for the sign-magnitude ALU.
package smalu_pkg;

  localparam int unsigned MagBits = 31;
  // Front stage, one stage per quotient bit, output register.
  localparam int unsigned Latency = MagBits + 2;

  typedef logic [MagBits-1:0] mag_t;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_DIV = 2'd3
  } mode_e;

  // Sideband that travels with each request through the divider stages.
  typedef struct packed {
    logic valid;
    logic is_div;
    logic div_zero;
    logic neg;
    mag_t mag;
  } meta_t;

  // Working state of the restoring divider.
  typedef struct packed {
    mag_t rem;
    mag_t dvd;
    mag_t quo;
    mag_t dsr;
  } div_t;

endpackage

[src/smalu_front.sv]
// Front stage: add, subtract and multiply, plus divider set-up, registered.
module smalu_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [1:0]          mode_i,
  input  logic                a_negative_i,
  input  smalu_pkg::mag_t     a_magnitude_i,
  input  logic                b_negative_i,
  input  smalu_pkg::mag_t     b_magnitude_i,
  output smalu_pkg::meta_t    meta_o,
  output smalu_pkg::div_t     div_o
);

  smalu_pkg::meta_t meta_d, meta_q;
  smalu_pkg::div_t  div_d, div_q;
  logic             b_sign;
  logic             a_ge_b;
  smalu_pkg::mag_t  sum;
  smalu_pkg::mag_t  diff_ab;
  smalu_pkg::mag_t  diff_ba;
  smalu_pkg::mag_t  prod;
  smalu_pkg::mag_t  res_mag;
  logic             res_neg;

  always_comb begin
    // Subtract is add with the second sign flipped.
    b_sign  = (smalu_pkg::mode_e'(mode_i) == smalu_pkg::MODE_SUB) ? ~b_negative_i
                                                                    : b_negative_i;
    a_ge_b  = a_magnitude_i >= b_magnitude_i;
    sum     = a_magnitude_i + b_magnitude_i;
    diff_ab = a_magnitude_i - b_magnitude_i;
    diff_ba = b_magnitude_i - a_magnitude_i;
    prod    = smalu_pkg::mag_t'(a_magnitude_i * b_magnitude_i);
    res_neg = 1'b0;
    res_mag = '0;
    unique case (smalu_pkg::mode_e'(mode_i)) inside
      smalu_pkg::MODE_ADD, smalu_pkg::MODE_SUB: begin
        if (a_negative_i == b_sign) begin
          res_mag = sum;
          res_neg = a_negative_i;
        end else if (a_ge_b) begin
          res_mag = diff_ab;
          res_neg = a_negative_i;
        end else begin
          res_mag = diff_ba;
          res_neg = b_sign;
        end
      end
      smalu_pkg::MODE_MUL: begin
        res_mag = prod;
        res_neg = a_negative_i ^ b_negative_i;
      end
      default: begin
        res_mag = '0;
        res_neg = a_negative_i ^ b_negative_i;
      end
    endcase
    meta_d.valid    = valid_i;
    meta_d.is_div   = smalu_pkg::mode_e'(mode_i) == smalu_pkg::MODE_DIV;
    meta_d.div_zero = b_magnitude_i == '0;
    meta_d.neg      = res_neg;
    meta_d.mag      = res_mag;
    div_d.rem       = '0;
    div_d.dvd       = a_magnitude_i;
    div_d.quo       = '0;
    div_d.dsr       = b_magnitude_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_q <= '0;
    end else begin
      meta_q <= meta_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
  end

  assign meta_o = meta_q;
  assign div_o  = div_q;

endmodule

[src/smalu_div_stage.sv]
// One restoring-division step: a quotient bit per stage, sideband carried along.
module smalu_div_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  smalu_pkg::meta_t  meta_i,
  input  smalu_pkg::div_t   div_i,
  output smalu_pkg::meta_t  meta_o,
  output smalu_pkg::div_t   div_o
);

  smalu_pkg::meta_t           meta_q;
  smalu_pkg::div_t            div_d, div_q;
  logic [smalu_pkg::MagBits:0] trial;
  logic                        fits;

  always_comb begin
    // Bring down the next dividend bit and try the divisor.
    trial     = {div_i.rem, div_i.dvd[smalu_pkg::MagBits-1]};
    fits      = trial >= {1'b0, div_i.dsr};
    div_d.rem = fits ? smalu_pkg::mag_t'(trial - {1'b0, div_i.dsr})
                     : smalu_pkg::mag_t'(trial);
    div_d.dvd = {div_i.dvd[smalu_pkg::MagBits-2:0], 1'b0};
    div_d.quo = {div_i.quo[smalu_pkg::MagBits-2:0], fits};
    div_d.dsr = div_i.dsr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_q <= '0;
    end else begin
      meta_q <= meta_i;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
  end

  assign meta_o = meta_q;
  assign div_o  = div_q;

endmodule

[src/sign_magnitude_alu.sv]
// Top level of the pipelined sign-magnitude ALU.
//
// Usage: drive mode_i and the two sign-magnitude operands with start high
// for one cycle per request. busy is never raised, so a request may be
// issued in every cycle and is taken at each edge where start is high.
// Each request gives exactly one result, shown for one cycle with done_o
// high, in request order.
// Pipeline: one front stage (add, subtract and a 31x31 multiply), one
// restoring-division stage per quotient bit (31), and the output register.
// Throughput: one request per cycle; the divider is fully pipelined.
// Add, subtract and multiply results ride alongside the divider stages.
// Reset (rst_ni low) clears every stage's valid bit; requests in flight
// are dropped and no result appears until new requests arrive.
// The receiver cannot stall, so results are never held back.
module sign_magnitude_alu (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             mode_i,
  input  logic                   a_negative_i,
  input  logic [smalu_pkg::MagBits-1:0] a_magnitude_i,
  input  logic                   b_negative_i,
  input  logic [smalu_pkg::MagBits-1:0] b_magnitude_i,
  output logic                   done_o,
  output logic                   result_negative_o,
  output logic [smalu_pkg::MagBits-1:0] result_magnitude_o,
  output logic                   divide_by_zero_o
);

  smalu_pkg::meta_t meta [smalu_pkg::MagBits+1];
  smalu_pkg::div_t  div  [smalu_pkg::MagBits+1];

  logic            done_q;
  logic            neg_d, neg_q;
  smalu_pkg::mag_t mag_d, mag_q;
  logic            dz_d, dz_q;

  assign busy = 1'b0;

  smalu_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (start),
    .mode_i        (mode_i),
    .a_negative_i  (a_negative_i),
    .a_magnitude_i (a_magnitude_i),
    .b_negative_i  (b_negative_i),
    .b_magnitude_i (b_magnitude_i),
    .meta_o        (meta[0]),
    .div_o         (div[0])
  );

  for (genvar s = 0; s < smalu_pkg::MagBits; s++) begin : g_div
    smalu_div_stage u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .meta_i (meta[s]),
      .div_i  (div[s]),
      .meta_o (meta[s+1]),
      .div_o  (div[s+1])
    );
  end

  always_comb begin
    smalu_pkg::meta_t m;
    m     = meta[smalu_pkg::MagBits];
    dz_d  = m.is_div & m.div_zero;
    if (m.is_div) begin
      mag_d = dz_d ? '0 : div[smalu_pkg::MagBits].quo;
    end else begin
      mag_d = m.mag;
    end
    // Zero is always positive.
    neg_d = m.neg & (mag_d != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= meta[smalu_pkg::MagBits].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    mag_q <= mag_d;
    dz_q  <= dz_d;
  end

  assign done_o             = done_q;
  assign result_negative_o  = neg_q;
  assign result_magnitude_o = mag_q;
  assign divide_by_zero_o   = dz_q;

  a_zero_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (result_magnitude_o == '0) |-> !result_negative_o)
    else $error("zero result given as negative");

  a_dz_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && divide_by_zero_o |-> (result_magnitude_o == '0) && !result_negative_o)
    else $error("divide by zero with non-zero result");

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    meta[smalu_pkg::MagBits].valid |=> done_o)
    else $error("result lost at output register");

endmodule
